// ----- hw/rtl/ptt_pkg.sv -----
// ----------------------------------------------------------------------------
// Periodic timer table package
// Word types, timer entry layout and code constants shared by the timer
// table modules.
// ----------------------------------------------------------------------------
`default_nettype none

package ptt_pkg;

	localparam int TIMERS_PER_BANK_DEF = 16;
	localparam int MAX_RESULTS         = 32;
	localparam int FIRE_CNT_W          = $clog2(MAX_RESULTS + 1);

	// Command codes of an input word.
	localparam logic [1:0] CMD_CREATE  = 2'd0;
	localparam logic [1:0] CMD_DESTROY = 2'd1;
	localparam logic [1:0] CMD_TICK    = 2'd2;

	// Kind codes of a result word.
	localparam logic [1:0] KIND_CREATE  = 2'd0;
	localparam logic [1:0] KIND_DESTROY = 2'd1;
	localparam logic [1:0] KIND_FIRED   = 2'd2;

	// Status codes of a result word.
	localparam logic [1:0] STAT_OK         = 2'd0;
	localparam logic [1:0] STAT_NOT_ACTIVE = 2'd1;
	localparam logic [1:0] STAT_FULL       = 2'd2;

	typedef struct packed {
		logic [1:0]  cmd;
		logic        bank;
		logic [31:0] period_ms;
		logic [31:0] handler_address;
		logic [3:0]  timer_id;
		logic [31:0] tick_ms;
	} ptt_in_t;

	typedef struct packed {
		logic [1:0]  kind;
		logic [1:0]  status;
		logic [3:0]  slot_index;
		logic        fired_bank;
		logic [31:0] target_address;
		logic        last;
	} ptt_out_t;

	// One timer slot as it travels around the ring.
	typedef struct packed {
		logic        active;
		logic [31:0] period;
		logic [31:0] elapsed;
		logic [31:0] handler;
	} ptt_entry_t;

	// Operation latched for the duration of one sweep.
	typedef struct packed {
		logic [1:0]  cmd;
		logic        bank;
		logic [31:0] period;
		logic [31:0] handler;
		logic [31:0] delta;
	} ptt_op_t;

	// What the sequencer tells the head about the slot now at the head.
	typedef struct packed {
		logic bank;
		logic id_match;
		logic found;
	} ptt_step_t;

	// What the head reports back about that slot.
	typedef struct packed {
		logic fire;
		logic create_hit;
		logic destroy_hit;
	} ptt_head_res_t;

endpackage

`default_nettype wire

// ----- hw/rtl/ptt_cell.sv -----
// ----------------------------------------------------------------------------
// Timer ring cell
// Holds one timer slot and takes its neighbor's slot when the ring shifts.
// ----------------------------------------------------------------------------
`default_nettype none

module ptt_cell (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              shift,
	input  wire ptt_pkg::ptt_entry_t d,
	output ptt_pkg::ptt_entry_t    q
);
	import ptt_pkg::*;

	logic        active_q;
	logic [31:0] period_q;
	logic [31:0] elapsed_q;
	logic [31:0] handler_q;

	// Only the active flag is reset; the stored values are read only when active.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q <= 1'b0;
		end else if (shift) begin
			active_q <= d.active;
		end
	end

	always_ff @(posedge clk) begin
		if (shift) begin
			period_q  <= d.period;
			elapsed_q <= d.elapsed;
			handler_q <= d.handler;
		end
	end

	assign q = '{active: active_q, period: period_q, elapsed: elapsed_q, handler: handler_q};

endmodule

`default_nettype wire

// ----- hw/rtl/ptt_head.sv -----
// ----------------------------------------------------------------------------
// Timer ring head
// Applies the current operation to the slot that passes the head of the ring.
// ----------------------------------------------------------------------------
`default_nettype none

module ptt_head (
	input  wire ptt_pkg::ptt_op_t    op,
	input  wire ptt_pkg::ptt_step_t  step,
	input  wire ptt_pkg::ptt_entry_t cur,
	output ptt_pkg::ptt_entry_t      nxt,
	output ptt_pkg::ptt_head_res_t   res
);
	import ptt_pkg::*;

	logic [32:0] sum;
	logic [31:0] sat;

	// The elapsed count saturates instead of wrapping.
	assign sum = {1'b0, cur.elapsed} + {1'b0, op.delta};
	assign sat = sum[32] ? '1 : sum[31:0];

	always_comb begin
		nxt = cur;
		res = '0;
		case (op.cmd)
			CMD_TICK: begin
				if (cur.active) begin
					if (sat >= cur.period) begin
						res.fire    = 1'b1;
						nxt.elapsed = '0;
					end else begin
						nxt.elapsed = sat;
					end
				end
			end
			CMD_CREATE: begin
				if (!cur.active && step.bank == op.bank && !step.found) begin
					nxt.active     = 1'b1;
					nxt.period     = op.period;
					nxt.elapsed    = '0;
					nxt.handler    = op.handler;
					res.create_hit = 1'b1;
				end
			end
			CMD_DESTROY: begin
				if (cur.active && step.bank == op.bank && step.id_match) begin
					nxt.active      = 1'b0;
					res.destroy_hit = 1'b1;
				end
			end
			default: begin
			end
		endcase
	end

endmodule

`default_nettype wire

// ----- hw/rtl/periodic_timer_table.sv -----
// ----------------------------------------------------------------------------
// Periodic timer table
// Two banks of periodic timers kept in a rotating ring of slot cells.
// ----------------------------------------------------------------------------
// The block holds 2*TIMERS_PER_BANK timers (gui bank first, then the plain
// bank) in a ring of cells. Every input word is served by one full rotation
// of the ring: each cycle, unless a new fire must wait for a full output
// register, the slot at the head passes through the head logic, which
// creates, destroys or advances it, and moves on to the tail. A final state
// then delivers the word's last result, if it has one, and the block returns
// to idle before it can take the next word. One word is worked on at a time;
// req_stall is high from acceptance until the word's final result has been
// loaded into the output register, and that register lets the next word
// enter while a result still waits. A create picks the lowest free slot
// of its bank, a destroy frees one slot, and a tick adds the elapsed
// milliseconds (zero counts as one, saturating) to every active timer and
// reports each timer that reaches its period, in ring order, up to 32 per
// tick. The last result of a word has last set. A fired report is held back
// one step so that last can be set on it once the sweep shows no later timer
// fires.
// ----------------------------------------------------------------------------
`default_nettype none

module periodic_timer_table #(
	parameter int TIMERS_PER_BANK = ptt_pkg::TIMERS_PER_BANK_DEF
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             req_valid,
	output logic                  req_stall,
	input  wire ptt_pkg::ptt_in_t req,
	output logic                  rsp_valid,
	input  wire logic             rsp_stall,
	output ptt_pkg::ptt_out_t     rsp
);
	import ptt_pkg::*;

	localparam int SLOTS = 2 * TIMERS_PER_BANK;
	localparam int KW    = $clog2(SLOTS);
	localparam int SW    = (TIMERS_PER_BANK > 1) ? $clog2(TIMERS_PER_BANK) : 1;

	typedef enum logic [2:0] {
		ST_IDLE  = 3'b001,
		ST_SWEEP = 3'b010,
		ST_FINAL = 3'b100
	} state_t;

	state_t          state_q;
	logic [KW-1:0]   k_q;
	ptt_op_t         op_q;
	logic [3:0]      id_q;
	logic            found_q;
	logic [3:0]      found_slot_q;
	logic            hit_q;
	logic [FIRE_CNT_W-1:0] fire_cnt_q;
	logic            pend_v_q;
	ptt_out_t        pend_q;
	logic            out_v_q;
	ptt_out_t        out_q;

	ptt_entry_t      cell_q [SLOTS];
	ptt_entry_t      head_nxt;
	ptt_head_res_t   head_res;
	ptt_step_t       step;

	logic            step_bank;
	logic [KW-1:0]   step_pos;
	logic [SW-1:0]   step_slot;
	logic            last_step;
	logic            report;
	logic            out_free;
	logic            advance;
	logic            final_done;
	logic            out_load;
	ptt_out_t        out_word;
	ptt_out_t        fire_word;
	logic            accept;

	// The gui bank occupies the first half of the ring order.
	assign step_bank = (k_q < KW'(TIMERS_PER_BANK));
	assign step_pos  = step_bank ? k_q : k_q - KW'(TIMERS_PER_BANK);
	assign step_slot = SW'(step_pos);
	assign last_step = (k_q == KW'(SLOTS - 1));

	assign step = '{
		bank:     step_bank,
		id_match: (32'(step_slot) == 32'(id_q)),
		found:    found_q
	};

	ptt_head u_head (
		.op  (op_q),
		.step(step),
		.cur (cell_q[0]),
		.nxt (head_nxt),
		.res (head_res)
	);

	// The ring: each cell takes its upper neighbor, the tail takes the head result.
	for (genvar i = 0; i < SLOTS; i++) begin : g_cell
		if (i == SLOTS - 1) begin : g_tail
			ptt_cell u_cell (
				.clk   (clk),
				.arst_n(arst_n),
				.shift (advance),
				.d     (head_nxt),
				.q     (cell_q[i])
			);
		end else begin : g_body
			ptt_cell u_cell (
				.clk   (clk),
				.arst_n(arst_n),
				.shift (advance),
				.d     (cell_q[i + 1]),
				.q     (cell_q[i])
			);
		end
	end

	assign accept   = req_valid && !req_stall;
	assign req_stall = (state_q != ST_IDLE);
	assign out_free = !out_v_q || !rsp_stall;
	assign report   = head_res.fire && (fire_cnt_q < FIRE_CNT_W'(MAX_RESULTS));

	// A new fire while one is pending pushes the pending one out first.
	assign advance = (state_q == ST_SWEEP) && (!(report && pend_v_q) || out_free);

	assign fire_word = '{
		kind:           KIND_FIRED,
		status:         STAT_OK,
		slot_index:     4'(step_slot),
		fired_bank:     step_bank,
		target_address: cell_q[0].handler,
		last:           1'b0
	};

	always_comb begin
		out_load   = 1'b0;
		out_word   = pend_q;
		final_done = 1'b0;
		if (state_q == ST_SWEEP) begin
			if (advance && report && pend_v_q) begin
				out_load = 1'b1;
			end
		end else if (state_q == ST_FINAL) begin
			case (op_q.cmd)
				CMD_TICK: begin
					out_word.last = 1'b1;
					out_load      = pend_v_q && out_free;
					final_done    = !pend_v_q || out_free;
				end
				CMD_CREATE: begin
					out_word = '{
						kind:           KIND_CREATE,
						status:         found_q ? STAT_OK : STAT_FULL,
						slot_index:     found_q ? found_slot_q : 4'd0,
						fired_bank:     op_q.bank,
						target_address: 32'd0,
						last:           1'b1
					};
					out_load   = out_free;
					final_done = out_free;
				end
				CMD_DESTROY: begin
					out_word = '{
						kind:           KIND_DESTROY,
						status:         hit_q ? STAT_OK : STAT_NOT_ACTIVE,
						slot_index:     id_q,
						fired_bank:     op_q.bank,
						target_address: 32'd0,
						last:           1'b1
					};
					out_load   = out_free;
					final_done = out_free;
				end
				default: begin
					final_done = 1'b1;
				end
			endcase
		end
	end

	// Sequencer and per-word bookkeeping.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			k_q        <= '0;
			found_q    <= 1'b0;
			hit_q      <= 1'b0;
			fire_cnt_q <= '0;
			pend_v_q   <= 1'b0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						state_q    <= ST_SWEEP;
						k_q        <= '0;
						found_q    <= 1'b0;
						hit_q      <= 1'b0;
						fire_cnt_q <= '0;
						pend_v_q   <= 1'b0;
					end
				end
				ST_SWEEP: begin
					if (advance) begin
						k_q <= k_q + KW'(1);
						if (head_res.create_hit) begin
							found_q <= 1'b1;
						end
						if (head_res.destroy_hit) begin
							hit_q <= 1'b1;
						end
						if (report) begin
							pend_v_q   <= 1'b1;
							fire_cnt_q <= fire_cnt_q + FIRE_CNT_W'(1);
						end
						if (last_step) begin
							state_q <= ST_FINAL;
						end
					end
				end
				ST_FINAL: begin
					if (final_done) begin
						state_q  <= ST_IDLE;
						pend_v_q <= 1'b0;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			op_q.cmd     <= req.cmd;
			op_q.bank    <= req.bank;
			op_q.period  <= req.period_ms;
			op_q.handler <= req.handler_address;
			op_q.delta   <= (req.tick_ms == 32'd0) ? 32'd1 : req.tick_ms;
			id_q         <= req.timer_id;
		end
		if (advance && head_res.create_hit) begin
			found_slot_q <= 4'(step_slot);
		end
		if (advance && report) begin
			pend_q <= fire_word;
		end
	end

	// Output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q <= 1'b0;
		end else if (out_load) begin
			out_v_q <= 1'b1;
		end else if (!rsp_stall) begin
			out_v_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			out_q <= out_word;
		end
	end

	assign rsp_valid = out_v_q;
	assign rsp       = out_q;

endmodule

`default_nettype wire

// ----- tb/sv/periodic_timer_table_tb.sv -----
// ----------------------------------------------------------------------------
// Periodic timer table testbench
// Drives create, destroy and tick words into the timer table and compares
// every result word with a cycle-free model of both timer banks, under random
// idling and stalling on both channels.
// ----------------------------------------------------------------------------
`default_nettype none

module periodic_timer_table_tb;
	import ptt_pkg::*;

	localparam int TIMERS      = TIMERS_PER_BANK_DEF;
	localparam int SLOTS       = 2 * TIMERS;
	localparam int CYCLE_LIMIT = 3_000_000;
	// One word takes a full ring rotation plus the output stage.
	localparam int SETTLE_CYCLES = 2 * TIMERS + 8;
	localparam int HOLD_CYCLES   = 500;

	localparam logic       BANK_GUI   = 1'b1;
	localparam logic       BANK_PLAIN = 1'b0;
	// The fourth command code has no meaning and the block drops such words.
	localparam logic [1:0] CMD_UNUSED = 2'd3;

	logic     clk       = 1'b0;
	logic     arst_n    = 1'b0;
	logic     req_valid = 1'b0;
	logic     req_stall;
	ptt_in_t  req       = '0;
	logic     rsp_valid;
	logic     rsp_stall = 1'b0;
	ptt_out_t rsp;

	// Model of the two banks, indexed by bank * TIMERS + slot.
	logic [31:0] timer_period  [SLOTS];
	logic [31:0] timer_elapsed [SLOTS];
	logic [31:0] timer_handler [SLOTS];
	logic        timer_active  [SLOTS];

	// Result words predicted but not yet seen on the result channel.
	ptt_out_t pending_results[$];

	int error_count  = 0;
	int cycle_count  = 0;
	// Set by a test to make the result side hold off for that many cycles.
	int hold_request = 0;
	int stall_left   = 0;
	// While set, neither side idles or stalls on its own.
	bit steady       = 1'b0;

	periodic_timer_table #(
		.TIMERS_PER_BANK(TIMERS)
	) dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.req_valid(req_valid),
		.req_stall(req_stall),
		.req      (req),
		.rsp_valid(rsp_valid),
		.rsp_stall(rsp_stall),
		.rsp      (rsp)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// A hung block must not keep the run going forever.
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("FAILED: results differ");
			$finish;
		end
	end

	// ------------------------------------------------------------------
	// Timer bank model
	// ------------------------------------------------------------------

	// Applies one accepted word to the model and queues the result words it
	// causes. A tick walks the gui bank first, then the plain bank, each in
	// ascending slot order, and marks the final fired word with last.
	function automatic void predict_word(ptt_in_t w);
		ptt_out_t    r;
		ptt_out_t    fired[$];
		logic [31:0] delta;
		logic [32:0] sum;
		int          e;
		bit          placed;

		r            = '0;
		r.fired_bank = w.bank;
		r.last       = 1'b1;
		placed       = 1'b0;
		case (w.cmd)
			CMD_CREATE: begin
				r.kind   = KIND_CREATE;
				r.status = STAT_FULL;
				for (int s = 0; s < TIMERS; s++) begin
					e = w.bank * TIMERS + s;
					if (!placed && !timer_active[e]) begin
						timer_period[e]  = w.period_ms;
						timer_elapsed[e] = '0;
						timer_handler[e] = w.handler_address;
						timer_active[e]  = 1'b1;
						r.status         = STAT_OK;
						r.slot_index     = 4'(s);
						placed           = 1'b1;
					end
				end
				pending_results.push_back(r);
			end
			CMD_DESTROY: begin
				r.kind       = KIND_DESTROY;
				r.status     = STAT_NOT_ACTIVE;
				r.slot_index = w.timer_id;
				if (w.timer_id < TIMERS) begin
					e = w.bank * TIMERS + w.timer_id;
					if (timer_active[e]) begin
						timer_active[e] = 1'b0;
						r.status        = STAT_OK;
					end
				end
				pending_results.push_back(r);
			end
			CMD_TICK: begin
				// A zero tick still advances every timer by one millisecond.
				delta = (w.tick_ms == '0) ? 32'd1 : w.tick_ms;
				for (int b = 1; b >= 0; b--) begin
					for (int s = 0; s < TIMERS; s++) begin
						e = b * TIMERS + s;
						if (timer_active[e]) begin
							sum = {1'b0, timer_elapsed[e]} + {1'b0, delta};
							// A count that wraps sticks at the top value.
							if (sum[32])
								sum[31:0] = '1;
							if (sum[31:0] >= timer_period[e]) begin
								timer_elapsed[e] = '0;
								if (fired.size() < MAX_RESULTS) begin
									r.kind           = KIND_FIRED;
									r.status         = STAT_OK;
									r.slot_index     = 4'(s);
									r.fired_bank     = b[0];
									r.target_address = timer_handler[e];
									r.last           = 1'b0;
									fired.push_back(r);
								end
							end else begin
								timer_elapsed[e] = sum[31:0];
							end
						end
					end
				end
				// A tick that fires nothing produces no word at all.
				if (fired.size() > 0) begin
					r      = fired.pop_back();
					r.last = 1'b1;
					fired.push_back(r);
				end
				foreach (fired[i])
					pending_results.push_back(fired[i]);
			end
			default: begin
			end
		endcase
	endfunction

	// ------------------------------------------------------------------
	// Result side: random stalls and the checker
	// ------------------------------------------------------------------

	// The stall pattern is mostly short bursts with the odd long one. A
	// hold-off asked by a test is counted down here, one cycle per edge.
	always @(posedge clk) begin
		int r;
		if (hold_request > 0) begin
			stall_left   = hold_request;
			hold_request = 0;
		end
		if (stall_left > 0) begin
			rsp_stall <= 1'b1;
			stall_left--;
		end else if (steady) begin
			rsp_stall <= 1'b0;
		end else begin
			r = $urandom_range(0, 99);
			if (r < 70) begin
				rsp_stall <= 1'b0;
			end else begin
				rsp_stall <= 1'b1;
				stall_left = (r < 96) ? $urandom_range(0, 3) : $urandom_range(10, 60);
			end
		end
	end

	function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
		if (got !== want) begin
			$display("%0t: %s mismatch: expected %h, actual %h", $time, name, want, got);
			error_count++;
		end
	endfunction

	// Every accepted result word is held against the oldest prediction.
	always @(posedge clk) begin
		ptt_out_t want;
		if (arst_n && rsp_valid && !rsp_stall) begin
			if (pending_results.size() == 0) begin
				$display("%0t: unexpected word: expected none, actual %h", $time, rsp);
				error_count++;
			end else begin
				want = pending_results.pop_front();
				check_field("kind", want.kind, rsp.kind);
				check_field("status", want.status, rsp.status);
				check_field("slot_index", want.slot_index, rsp.slot_index);
				check_field("fired_bank", want.fired_bank, rsp.fired_bank);
				check_field("target_address", want.target_address, rsp.target_address);
				check_field("last", want.last, rsp.last);
			end
		end
	end

	// ------------------------------------------------------------------
	// Request side
	// ------------------------------------------------------------------

	function automatic ptt_in_t random_word();
		ptt_in_t w;
		w.cmd             = 2'($urandom_range(0, 3));
		w.bank            = 1'($urandom);
		w.period_ms       = $urandom;
		w.handler_address = $urandom;
		w.timer_id        = 4'($urandom);
		w.tick_ms         = $urandom;
		return w;
	endfunction

	function automatic ptt_in_t command_word(logic [1:0] cmd, logic bank,
			logic [31:0] period, logic [31:0] handler, logic [3:0] id,
			logic [31:0] tick);
		ptt_in_t w;
		w.cmd             = cmd;
		w.bank            = bank;
		w.period_ms       = period;
		w.handler_address = handler;
		w.timer_id        = id;
		w.tick_ms         = tick;
		return w;
	endfunction

	// Offers a word and holds it until the block takes it. Called at a rising
	// edge; returns at the edge of acceptance with valid still high, so a
	// following word goes out without valid dropping in between.
	task automatic send_word(ptt_in_t w);
		req       <= w;
		req_valid <= 1'b1;
		do @(posedge clk); while (req_stall);
		predict_word(w);
	endtask

	// Drops valid for a number of cycles and shows junk on the payload.
	task automatic pause_sender(int cycles);
		if (cycles > 0) begin
			req_valid <= 1'b0;
			req       <= random_word();
			repeat (cycles) @(posedge clk);
		end
	endtask

	function automatic int sender_gap();
		int r;
		if (steady)
			return 0;
		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		if (r < 95)
			return $urandom_range(1, 4);
		return $urandom_range(10, 60);
	endfunction

	// Stops offering words until every predicted result has come back.
	task automatic wait_drained();
		req_valid <= 1'b0;
		do @(posedge clk); while (pending_results.size() != 0);
	endtask

	// Builds one random word. Most words are meaningful commands with random
	// content: periods are mostly short so that ticks keep firing timers, and
	// most destroys aim at a timer that is running.
	function automatic ptt_in_t make_random_word();
		ptt_in_t w;
		int      active_ids[$];
		int      r;
		int      p;

		w = random_word();
		r = $urandom_range(0, 99);
		if (r < 36) begin
			w.cmd = CMD_CREATE;
			p     = $urandom_range(0, 9);
			if (p < 6)
				w.period_ms = $urandom_range(0, 40);
			else if (p == 8)
				w.period_ms = '1;
			else if (p == 9)
				w.period_ms = '0;
		end else if (r < 66) begin
			w.cmd = CMD_DESTROY;
			for (int s = 0; s < TIMERS; s++)
				if (timer_active[w.bank * TIMERS + s])
					active_ids.push_back(s);
			if (active_ids.size() > 0 && $urandom_range(0, 9) < 7)
				w.timer_id = 4'(active_ids[$urandom_range(0, active_ids.size() - 1)]);
		end else if (r < 95) begin
			w.cmd = CMD_TICK;
			p     = $urandom_range(0, 9);
			if (p < 7)
				w.tick_ms = $urandom_range(0, 12);
			else if (p < 9)
				w.tick_ms = $urandom_range(13, 200);
		end else begin
			w.cmd = CMD_UNUSED;
		end
		return w;
	endfunction

	// ------------------------------------------------------------------
	// Tests
	// ------------------------------------------------------------------

	// Covers each command, the zero tick, a saturating count, a zero period,
	// destroys of free slots, a tick that fires nothing and an unused code.
	task automatic test_special_cases();
		// The zero-period timer fires on every tick.
		send_word(command_word(CMD_CREATE, BANK_GUI, 32'h0, 32'hFFFF_FFFF, 4'h0, 32'h0));
		send_word(command_word(CMD_CREATE, BANK_PLAIN, 32'hFFFF_FFFF, 32'h0, 4'hF, 32'h0));
		pause_sender(sender_gap());
		// A zero tick moves the plain timer to one.
		send_word(command_word(CMD_TICK, BANK_PLAIN, 32'h0, 32'h0, 4'h0, 32'h0));
		// One plus the largest tick wraps, so the plain timer sticks at the
		// top and fires together with the gui timer.
		send_word(command_word(CMD_TICK, BANK_GUI, 32'h0, 32'h0, 4'h0, 32'hFFFF_FFFF));
		send_word(command_word(CMD_CREATE, BANK_GUI, 32'd5, 32'h5555_AAAA, 4'h0, 32'h0));
		send_word(command_word(CMD_TICK, BANK_GUI, 32'h0, 32'h0, 4'h0, 32'd1));
		pause_sender(sender_gap());
		send_word(command_word(CMD_DESTROY, BANK_GUI, 32'h0, 32'h0, 4'h0, 32'h0));
		// The same slot again is no longer running.
		send_word(command_word(CMD_DESTROY, BANK_GUI, 32'h0, 32'h0, 4'h0, 32'h0));
		send_word(command_word(CMD_DESTROY, BANK_PLAIN, 32'h0, 32'h0, 4'hF, 32'h0));
		send_word(command_word(CMD_UNUSED, BANK_GUI, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
			4'hF, 32'hFFFF_FFFF));
		// Nothing reaches its period here, so no word comes back.
		send_word(command_word(CMD_TICK, BANK_PLAIN, 32'h0, 32'h0, 4'h0, 32'd2));
		pause_sender(sender_gap());
	endtask

	// Fills the plain bank and asks for one timer more than it holds.
	task automatic test_bank_full();
		for (int i = 1; i < TIMERS; i++) begin
			send_word(command_word(CMD_CREATE, BANK_PLAIN, $urandom_range(0, 20),
				$urandom, 4'h0, 32'h0));
			pause_sender(sender_gap());
		end
		send_word(command_word(CMD_CREATE, BANK_PLAIN, 32'd7, 32'h1234_5678, 4'h0, 32'h0));
		pause_sender(sender_gap());
	endtask

	// The result side holds off for a long stretch while words keep coming,
	// so the output register fills and the block stalls its input. A largest
	// tick fires every running timer at once. Afterwards the sender waits
	// for every result before it goes on.
	task automatic test_result_hold();
		wait_drained();
		hold_request = HOLD_CYCLES;
		send_word(command_word(CMD_TICK, BANK_GUI, 32'h0, 32'h0, 4'h0, 32'hFFFF_FFFF));
		send_word(command_word(CMD_CREATE, BANK_GUI, 32'd0, $urandom, 4'h0, 32'h0));
		send_word(command_word(CMD_DESTROY, BANK_PLAIN, 32'h0, 32'h0, 4'h3, 32'h0));
		send_word(command_word(CMD_TICK, BANK_PLAIN, 32'h0, 32'h0, 4'h0, 32'h0));
		send_word(command_word(CMD_CREATE, BANK_PLAIN, 32'd2, $urandom, 4'h0, 32'h0));
		send_word(command_word(CMD_TICK, BANK_GUI, 32'h0, 32'h0, 4'h0, 32'hFFFF_FFFF));
		wait_drained();
	endtask

	// Random words until the given number of meaningful ones has gone in.
	task automatic test_random(int count);
		ptt_in_t w;
		int      sent;

		sent = 0;
		while (sent < count) begin
			w = make_random_word();
			send_word(w);
			if (w.cmd != CMD_UNUSED)
				sent++;
			pause_sender(sender_gap());
		end
	endtask

	initial begin
		foreach (timer_active[i])
			timer_active[i] = 1'b0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_special_cases();
		test_bank_full();
		test_random(140);
		test_result_hold();
		// A stretch where both sides run at full rate.
		steady = 1'b1;
		test_random(40);
		steady = 1'b0;
		test_random(100);

		wait_drained();
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (error_count == 0 && pending_results.size() == 0) begin
			$display("PASSED: all results match");
		end else begin
			$display("FAILED: results differ");
		end
		$finish;
	end

endmodule

`default_nettype wire
